/* src/rlss_pkg.sv */
package rlss_pkg;

  localparam int MAX_LIGHTS_DEF = 256;
  localparam int WORD_W         = 24;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FULL = 8'hFF;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_SLOT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_LIGHT_COUNT = 2'd0,
    REG_RED_LANE    = 2'd1,
    REG_GREEN_LANE  = 2'd2,
    REG_BLUE_LANE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_BODY,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READY,
    ST_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } seq_ctl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } frame_res_t;

  // lane three has no place in the word, so the colour drops out
  function automatic logic [WORD_W-1:0] place_lane(input logic [7:0] colour,
                                                   input logic [1:0] lane);
    logic [WORD_W-1:0] w;
    w = '0;
    case (lane)
      2'd0: w[7:0]   = colour;
      2'd1: w[15:8]  = colour;
      2'd2: w[23:16] = colour;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

/* src/rgb_led_strip_frame_serializer.sv */
// Light writes and start words are taken one per cycle while s_tready is high and act
// at the accepting edge. For a byte-slot word the frame buffer read is registered, and
// the result is loaded into the output register from the exec state once no earlier
// byte still waits there; s_tready stays low until the slot is done.
// Reset is synchronous; afterwards a clearing pass zeroes the frame buffer with
// s_tready low. Configuration writes are taken throughout.
module rgb_led_strip_frame_serializer #(
  parameter int MAX_LIGHTS = rlss_pkg::MAX_LIGHTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // light_index, red, green, blue
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // spi_byte
  output logic        m_tuser,   // frame_begin
  output logic        m_tlast,   // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import rlss_pkg::*;

  localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int IW = (AW > 8) ? AW : 8;

  ctl_state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [8:0]    light_count;
  logic [1:0]    red_lane, green_lane, blue_lane;
  logic [8:0]    active_count;

  logic          s_acc;
  op_t           in_op;
  logic [7:0]    in_index;
  logic [IW-1:0] idx_wide;
  logic          idx_ok;
  logic          clearing;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_index;
  logic [WORD_W-1:0] rd_data;

  seq_ctl_t   ctl;
  frame_res_t res;
  logic       busy;
  logic       go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_count <= 9'd256;
      red_lane    <= 2'd2;
      green_lane  <= 2'd0;
      blue_lane   <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_LIGHT_COUNT: light_count <= cfg_data;
        REG_RED_LANE:    red_lane    <= cfg_data[1:0];
        REG_GREEN_LANE:  green_lane  <= cfg_data[1:0];
        REG_BLUE_LANE:   blue_lane   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(light_count) > MAX_LIGHTS) begin
      active_count = 9'(MAX_LIGHTS);
    end else begin
      active_count = light_count;
    end
  end

  assign s_tready = (state == ST_READY);
  assign s_acc    = s_tvalid && s_tready;
  assign in_op    = op_t'(s_tuser);
  assign in_index = s_tdata[7:0];
  assign idx_wide = IW'(in_index);
  assign idx_ok   = ({1'b0, in_index} < active_count) && (int'(in_index) < MAX_LIGHTS);
  assign clearing = (state == ST_CLEAR);

  assign wr_en   = clearing || (s_acc && (in_op == OP_WRITE) && idx_ok);
  assign wr_addr = clearing ? clr_addr : idx_wide[AW-1:0];
  assign wr_data = clearing ? '0 :
                   (place_lane(s_tdata[15:8], red_lane)
                  | place_lane(s_tdata[23:16], green_lane)
                  | place_lane(s_tdata[31:24], blue_lane));
  assign rd_en   = s_acc && (in_op == OP_SLOT);

  // a slot finishes once the output register can take its byte, or at once if idle
  assign go        = (state == ST_EXEC) && (!busy || !m_tvalid || m_tready);
  assign ctl.start = s_acc && (in_op == OP_START);
  assign ctl.step  = go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(MAX_LIGHTS - 1)) begin
          state_next = ST_READY;
        end
      end
      ST_READY: begin
        if (s_acc && (in_op == OP_SLOT)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_next = ST_READY;
        end
      end
      default: state_next = ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && busy) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && busy) begin
      m_tdata <= res.data;
      m_tuser <= res.first;
      m_tlast <= res.last;
    end
  end

  rlss_store #(
    .DEPTH (MAX_LIGHTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_index),
    .rd_data (rd_data)
  );

  rlss_seq #(
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .active_count (active_count),
    .word         (rd_data),
    .busy         (busy),
    .rd_index     (rd_index),
    .res          (res)
  );

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (go && busy) |=> m_tvalid)
    else $error("byte not loaded into output register");

  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    (go && busy && res.last) |=> !busy)
    else $error("sequencer still busy after final byte");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (in_op == OP_START) && !busy) |=> busy)
    else $error("start word did not arm a transfer");

  a_no_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (in_op == OP_SLOT)) |=> !s_tready)
    else $error("word accepted while a byte slot is in progress");

endmodule

/* src/rlss_store.sv */
module rlss_store #(
  parameter int DEPTH = rlss_pkg::MAX_LIGHTS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [rlss_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [rlss_pkg::WORD_W-1:0] rd_data
);
  import rlss_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/rlss_seq.sv */
module rlss_seq #(
  parameter int MAX_LIGHTS = rlss_pkg::MAX_LIGHTS_DEF,
  localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rlss_pkg::seq_ctl_t          ctl,
  input  logic [8:0]                  active_count,
  input  logic [rlss_pkg::WORD_W-1:0] word,
  output logic                        busy,
  output logic [AW-1:0]               rd_index,
  output rlss_pkg::frame_res_t        res
);
  import rlss_pkg::*;

  localparam int LW = (AW > 9) ? AW : 9;

  phase_t      phase, phase_next;
  logic [8:0]  light_counter, light_counter_next;
  logic [8:0]  sent_count, sent_count_next;
  logic [1:0]  byte_counter, byte_counter_next;
  logic [5:0]  tail_counter, tail_counter_next;
  logic [5:0]  groups;
  logic [8:0]  light_inc;
  logic [5:0]  tail_inc;
  logic [LW-1:0] lc_wide;

  // four tail bytes per started group of sixteen
  assign groups    = {1'b0, sent_count[8:4]} + 6'(|sent_count[3:0]);
  assign light_inc = light_counter + 9'd1;
  assign tail_inc  = tail_counter + 6'd1;
  assign lc_wide   = LW'(light_counter);
  assign rd_index  = lc_wide[AW-1:0];
  assign busy      = (phase != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      light_counter <= '0;
      sent_count    <= '0;
      byte_counter  <= '0;
      tail_counter  <= '0;
    end else begin
      phase         <= phase_next;
      light_counter <= light_counter_next;
      sent_count    <= sent_count_next;
      byte_counter  <= byte_counter_next;
      tail_counter  <= tail_counter_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    light_counter_next = light_counter;
    sent_count_next    = sent_count;
    byte_counter_next  = byte_counter;
    tail_counter_next  = tail_counter;
    res                = '0;
    case (phase)
      PH_HEAD: begin
        res.data  = BYTE_ZERO;
        res.first = (byte_counter == 2'd0);
        res.last  = (byte_counter == 2'd3) && (sent_count == 9'd0);
        if (ctl.step) begin
          if (byte_counter == 2'd3) begin
            byte_counter_next = '0;
            if (sent_count == 9'd0) begin
              phase_next = PH_IDLE;
            end else begin
              light_counter_next = '0;
              phase_next         = PH_BODY;
            end
          end else begin
            byte_counter_next = byte_counter + 2'd1;
          end
        end
      end
      PH_BODY: begin
        case (byte_counter)
          2'd0:    res.data = BYTE_FULL;
          2'd1:    res.data = word[7:0];
          2'd2:    res.data = word[15:8];
          default: res.data = word[23:16];
        endcase
        if (ctl.step) begin
          if (byte_counter == 2'd3) begin
            byte_counter_next  = '0;
            light_counter_next = light_inc;
            if (light_inc >= sent_count) begin
              tail_counter_next = '0;
              phase_next        = PH_TAIL;
            end
          end else begin
            byte_counter_next = byte_counter + 2'd1;
          end
        end
      end
      PH_TAIL: begin
        res.data = BYTE_FULL;
        res.last = (byte_counter == 2'd3) && (tail_inc >= groups);
        if (ctl.step) begin
          if (byte_counter == 2'd3) begin
            byte_counter_next = '0;
            tail_counter_next = tail_inc;
            if (tail_inc >= groups) begin
              phase_next = PH_IDLE;
            end
          end else begin
            byte_counter_next = byte_counter + 2'd1;
          end
        end
      end
      default: begin
        if (ctl.start) begin
          phase_next         = PH_HEAD;
          sent_count_next    = active_count;
          light_counter_next = '0;
          byte_counter_next  = '0;
          tail_counter_next  = '0;
        end
      end
    endcase
  end

endmodule

/* test/spi_frame_checker.sv */
`timescale 1ns / 1ps
module spi_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // light_index, red, green, blue
  input  logic [1:0]  s_tuser,   // op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // spi_byte
  input  logic        m_tuser,   // frame_begin
  input  logic        m_tlast,   // frame_end
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          errors,
  output int          outstanding
);
  import rlss_pkg::*;

  localparam int LIGHTS = MAX_LIGHTS_DEF;

  logic [23:0] light_words [LIGHTS];
  phase_t      phase;
  logic [8:0]  light_pos;
  logic [1:0]  byte_pos;
  logic [4:0]  tail_pos;
  logic [8:0]  latched_count;

  logic [8:0]  count_reg;
  logic [1:0]  red_lane;
  logic [1:0]  green_lane;
  logic [1:0]  blue_lane;

  frame_res_t  expected_bytes [$];

  function automatic logic [23:0] lane_word(input logic [7:0] colour, input logic [1:0] lane);
    logic [23:0] w;
    w = '0;
    if (lane != 2'd3)
      w = {16'd0, colour} << (8 * int'(lane));
    return w;
  endfunction

  task automatic note_error(input string what, input logic [7:0] exp_v, input logic [7:0] act_v);
    errors = errors + 1;
    $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, exp_v, act_v);
  endtask

  task automatic predict_word(input logic [1:0] op, input logic [7:0] idx,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
    frame_res_t  res;
    logic [8:0]  active;
    logic [23:0] word;
    int          groups;
    res    = '0;
    active = (count_reg > 9'(LIGHTS)) ? 9'(LIGHTS) : count_reg;
    case (op)
      OP_WRITE: begin
        if ({1'b0, idx} < active)
          light_words[idx] = lane_word(red, red_lane) | lane_word(green, green_lane)
                           | lane_word(blue, blue_lane);
      end
      OP_START: begin
        // a start while a frame is running is dropped
        if (phase == PH_IDLE) begin
          phase         = PH_HEAD;
          latched_count = active;
          light_pos     = '0;
          byte_pos      = '0;
          tail_pos      = '0;
        end
      end
      OP_SLOT: begin
        if (phase != PH_IDLE) begin
          case (phase)
            PH_HEAD: begin
              res.data  = BYTE_ZERO;
              res.first = (byte_pos == 2'd0);
              if (byte_pos == 2'd3) begin
                byte_pos = '0;
                if (latched_count == 9'd0) begin
                  res.last = 1'b1;
                  phase    = PH_IDLE;
                end else begin
                  light_pos = '0;
                  phase     = PH_BODY;
                end
              end else begin
                byte_pos = byte_pos + 2'd1;
              end
            end
            PH_BODY: begin
              word = light_words[light_pos[7:0]];
              if (byte_pos == 2'd0)
                res.data = BYTE_FULL;
              else
                res.data = word[8 * (int'(byte_pos) - 1) +: 8];
              if (byte_pos == 2'd3) begin
                byte_pos  = '0;
                light_pos = light_pos + 9'd1;
                if (light_pos >= latched_count) begin
                  tail_pos = '0;
                  phase    = PH_TAIL;
                end
              end else begin
                byte_pos = byte_pos + 2'd1;
              end
            end
            default: begin
              // four 0xFF per started group of sixteen lights
              groups   = (int'(latched_count) + 15) / 16;
              res.data = BYTE_FULL;
              if (byte_pos == 2'd3) begin
                byte_pos = '0;
                tail_pos = tail_pos + 5'd1;
                if (int'(tail_pos) >= groups) begin
                  res.last = 1'b1;
                  phase    = PH_IDLE;
                end
              end else begin
                byte_pos = byte_pos + 2'd1;
              end
            end
          endcase
          expected_bytes.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    frame_res_t exp_w;
    if (rst) begin
      for (int i = 0; i < LIGHTS; i++)
        light_words[i] = '0;
      phase         = PH_IDLE;
      light_pos     = '0;
      byte_pos      = '0;
      tail_pos      = '0;
      latched_count = '0;
      count_reg     = 9'd256;
      red_lane      = 2'd2;
      green_lane    = 2'd0;
      blue_lane     = 2'd1;
      expected_bytes.delete();
      errors        = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LIGHT_COUNT: count_reg  = cfg_data;
          REG_RED_LANE:    red_lane   = cfg_data[1:0];
          REG_GREEN_LANE:  green_lane = cfg_data[1:0];
          REG_BLUE_LANE:   blue_lane  = cfg_data[1:0];
          default: ;
        endcase
      end
      // output first: a word taken at this edge cannot have its byte out yet
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected byte, expected none, got %02h begin %b end %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          exp_w = expected_bytes.pop_front();
          if (m_tdata !== exp_w.data)
            note_error("spi_byte", exp_w.data, m_tdata);
          if (m_tuser !== exp_w.first)
            note_error("frame_begin", {7'd0, exp_w.first}, {7'd0, m_tuser});
          if (m_tlast !== exp_w.last)
            note_error("frame_end", {7'd0, exp_w.last}, {7'd0, m_tlast});
        end
      end
      if (s_tvalid && s_tready)
        predict_word(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]);
    end
    outstanding <= expected_bytes.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rlss_pkg::*;

  localparam int         LIMIT        = 400000;
  localparam int         SETTLE       = 16;
  localparam int         LONG_HOLD    = 300;
  localparam int         RANDOM_ITEMS = 1050;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int chk_errors;
  int chk_outstanding;
  int cycle_count    = 0;
  int sent_words     = 0;
  int long_hold_req  = 0;
  int long_hold_done = 0;
  bit send_burst     = 0;

  rgb_led_strip_frame_serializer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spi_frame_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (chk_errors),
    .outstanding (chk_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, stretches without any, and one long hold-off on request
  initial begin
    int gap;
    int taken;
    bit rx_burst;
    taken    = 0;
    rx_burst = 0;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req != long_hold_done) begin
        long_hold_done = long_hold_done + 1;
        gap = LONG_HOLD;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken = taken + 1;
      if (taken % 64 == 0)
        rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {blue, green, red, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_words = sent_words + 1;
  endtask

  function automatic logic [7:0] pick_colour();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_index(input int n_lights);
    if (n_lights > 0 && $urandom_range(0, 3) != 0)
      return 8'($urandom_range(0, n_lights - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] pick_lane();
    return ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
  endfunction

  task automatic send_op(input logic [1:0] op);
    push_word(op, 8'($urandom), pick_colour(), pick_colour(), pick_colour());
  endtask

  task automatic send_write(input int n_lights);
    push_word(OP_WRITE, pick_index(n_lights), pick_colour(), pick_colour(), pick_colour());
  endtask

  // quiet the input and let every expected byte out before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t which, input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [8:0] count, input logic [1:0] red_l,
                             input logic [1:0] green_l, input logic [1:0] blue_l);
    write_reg(REG_LIGHT_COUNT, count);
    write_reg(REG_RED_LANE, {7'($urandom), red_l});
    write_reg(REG_GREEN_LANE, {7'($urandom), green_l});
    write_reg(REG_BLUE_LANE, {7'($urandom), blue_l});
    cfg_valid <= 1'b0;
  endtask

  // a start and the byte slots of one frame, with writes and odd words mixed in
  task automatic run_frame(input int n_lights, input bit broken);
    int total;
    int cut;
    int change_at;
    total = 4 + 4 * n_lights + 4 * ((n_lights + 15) / 16);
    repeat ($urandom_range(0, 4)) send_write(n_lights);
    send_op(OP_START);
    if ($urandom_range(0, 5) == 0)
      send_op(OP_START);
    cut       = broken ? $urandom_range(0, total - 1) : total;
    change_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cut) : -1;
    for (int k = 0; k < cut; k++) begin
      if (k == change_at) begin
        // count is latched at start, so this must not disturb the running frame
        drain();
        write_reg(REG_LIGHT_COUNT, 9'($urandom));
        cfg_valid <= 1'b0;
      end
      if ($urandom_range(0, 7) == 0)
        send_write(n_lights);
      if ($urandom_range(0, 31) == 0)
        send_op(($urandom_range(0, 1) == 0) ? OP_UNUSED : OP_START);
      send_op(OP_SLOT);
    end
  endtask

  initial begin
    int     random_start;
    int     n_lights;
    logic [8:0] big_count;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset lanes, idle words, collisions, dropped lane, busy start, empty frame
    push_word(OP_WRITE, 8'd0, 8'hFF, 8'h00, 8'hAA);
    push_word(OP_WRITE, 8'd255, 8'h01, 8'h80, 8'h7F);
    push_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(OP_SLOT, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();
    load_config(9'd1, 2'd0, 2'd0, 2'd3);
    push_word(OP_WRITE, 8'd0, 8'h0F, 8'hF0, 8'h55);
    push_word(OP_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF);
    send_op(OP_START);
    send_op(OP_START);
    repeat (2) send_op(OP_SLOT);
    push_word(OP_WRITE, 8'd0, 8'h3C, 8'hC3, 8'hFF);
    repeat (10) send_op(OP_SLOT);
    drain();
    write_reg(REG_LIGHT_COUNT, 9'd0);
    cfg_valid <= 1'b0;
    send_op(OP_START);
    repeat (5) send_op(OP_SLOT);

    // one full-length frame while the receiver holds off, so the input backs up
    drain();
    case ($urandom_range(0, 2))
      0:       big_count = 9'd256;
      1:       big_count = 9'd300;
      default: big_count = 9'd511;
    endcase
    load_config(big_count, pick_lane(), pick_lane(), pick_lane());
    send_burst = 1;
    repeat (40) send_write(256);
    long_hold_req = long_hold_req + 1;
    run_frame(256, 0);

    random_start = sent_words;
    while (sent_words - random_start < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0:       n_lights = 0;
        1:       n_lights = 1;
        default: n_lights = $urandom_range(1, 20);
      endcase
      load_config(9'(n_lights), pick_lane(), pick_lane(), pick_lane());
      send_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        run_frame(n_lights, $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 6)) send_op(2'($urandom));
      end
    end

    drain();
    if (chk_errors == 0 && chk_outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/rlss_pkg.sv
src/rlss_store.sv
src/rlss_seq.sv
src/rgb_led_strip_frame_serializer.sv
test/spi_frame_checker.sv
test/tb.sv
